// File: rtl/brq_pkg.sv
`default_nettype none

package brq_pkg;

   localparam logic       CMD_SUBMIT        = 1'b0;
   localparam logic       CMD_EVENT         = 1'b1;

   localparam logic [1:0] KIND_START        = 2'd0;
   localparam logic [1:0] KIND_DONE         = 2'd1;
   localparam logic [1:0] KIND_REJECT       = 2'd2;

   localparam logic [5:0] CARD_CMD_READ     = 6'd17;
   localparam logic [5:0] CARD_CMD_WRITE    = 6'd24;
   localparam logic [7:0] DCTRL_BASE        = 8'h90;
   localparam logic [7:0] DCTRL_READ        = 8'h02;
   localparam logic [31:0] DATA_ERR_MASK    = 32'h0000_002A;
   localparam int          BLOCK_SHIFT      = 9;

   localparam int          CSR_INDEX_WIDTH  = 1;
   localparam int          CSR_DATA_WIDTH   = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGH_CAPACITY = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RETRY_LIMIT   = 1'b1;
   localparam logic [2:0]  RETRY_LIMIT_RESET = 3'd3;

   localparam int          RSP_DEPTH        = 4;
   localparam int          RSP_PTR_WIDTH    = 2;
   localparam int          RSP_CNT_WIDTH    = 3;

   typedef struct packed {
      logic [31:0] block_number;
      logic        is_read;
      logic [15:0] byte_count;
      logic [31:0] buffer_address;
      logic [7:0]  request_tag;
   } req_entry_type;

   typedef struct packed {
      logic          command;
      req_entry_type entry;
      logic [31:0]   transfer_status;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [5:0]  card_command;
      logic [31:0] card_argument;
      logic [15:0] data_length;
      logic [7:0]  data_control;
      logic [31:0] dma_address;
      logic [7:0]  done_tag;
      logic        failed;
      logic [31:0] error_status;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic first;
      logic second;
   } rsp_push_type;

   function automatic rsp_item_type make_start(input req_entry_type e, input logic hc);
      rsp_item_type r;
      r               = '0;
      r.result_kind   = KIND_START;
      r.card_command  = e.is_read ? CARD_CMD_READ : CARD_CMD_WRITE;
      r.card_argument = hc ? e.block_number : (e.block_number << BLOCK_SHIFT);
      r.data_length   = e.byte_count;
      r.data_control  = DCTRL_BASE | (e.is_read ? DCTRL_READ : 8'h00);
      r.dma_address   = e.buffer_address;
      r.done_tag      = e.request_tag;
      r.last          = 1'b1;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/brq_if.sv
`default_nettype none

interface brq_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] block_number;
   logic        is_read;
   logic [15:0] byte_count;
   logic [31:0] buffer_address;
   logic [7:0]  request_tag;
   logic [31:0] transfer_status;

   modport source (
      output valid, command, block_number, is_read, byte_count, buffer_address,
             request_tag, transfer_status,
      input  ready
   );
   modport sink (
      input  valid, command, block_number, is_read, byte_count, buffer_address,
             request_tag, transfer_status,
      output ready
   );
endinterface

interface brq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [5:0]  card_command;
   logic [31:0] card_argument;
   logic [15:0] data_length;
   logic [7:0]  data_control;
   logic [31:0] dma_address;
   logic [7:0]  done_tag;
   logic        failed;
   logic [31:0] error_status;
   logic        last;

   modport source (
      output valid, result_kind, card_command, card_argument, data_length,
             data_control, dma_address, done_tag, failed, error_status, last,
      input  ready
   );
   modport sink (
      input  valid, result_kind, card_command, card_argument, data_length,
             data_control, dma_address, done_tag, failed, error_status, last,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/brq_queue.sv
`default_nettype none

module brq_queue
   import brq_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire q_ctrl_type                   ctrl,
   input  wire req_entry_type                push_entry,
   output req_entry_type                     head_entry,
   output req_entry_type                     next_entry,
   output logic [$clog2(DEPTH+1)-1:0]        count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   req_entry_type store_ff [DEPTH];

   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   req_entry_type h_ff, h_in;
   req_entry_type n_ff, n_in;
   req_entry_type rd_ff;
   logic [IW:0]   rd_sum;
   logic [IW-1:0] rd_addr;

   function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
      return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   // head and the entry behind it sit in registers; memory prefetches head+2
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      h_in     = h_ff;
      n_in     = n_ff;
      if (ctrl.push) begin
         tail_in  = next_slot(tail_ff);
         count_in = count_ff + 1'b1;
         if (count_ff == '0) begin
            h_in = push_entry;
         end
         if (count_ff == CW'(1)) begin
            n_in = push_entry;
         end
      end
      if (ctrl.pop) begin
         head_in  = next_slot(head_ff);
         count_in = count_ff - 1'b1;
         h_in     = n_ff;
         n_in     = rd_ff;
      end
      rd_sum = {1'b0, head_in} + (IW+1)'(2);
      if (rd_sum >= (IW+1)'(DEPTH)) begin
         rd_sum = rd_sum - (IW+1)'(DEPTH);
      end
      rd_addr = rd_sum[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      n_ff <= n_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         store_ff[tail_ff] <= push_entry;
      end
   end

   // bypass a write that lands on the prefetch slot in the same cycle
   always_ff @(posedge clock) begin
      if (ctrl.push && (tail_ff == rd_addr)) begin
         rd_ff <= push_entry;
      end else begin
         rd_ff <= store_ff[rd_addr];
      end
   end

   assign head_entry = h_ff;
   assign next_entry = n_ff;
   assign count      = count_ff;

endmodule

`default_nettype wire

// File: rtl/brq_rsp_fifo.sv
`default_nettype none

module brq_rsp_fifo
   import brq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rsp_push_type             push,
   input  wire rsp_item_type             first_item,
   input  wire rsp_item_type             second_item,
   output logic [RSP_CNT_WIDTH-1:0]      level,
   brq_rsp_if.source                     rsp_chan
);

   rsp_item_type             slot_ff [RSP_DEPTH];
   logic [RSP_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_WIDTH-1:0] count_ff, count_in;
   logic                     pop;
   rsp_item_type             out_item;

   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_WIDTH'(push.first) + RSP_PTR_WIDTH'(push.second);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_WIDTH'(pop);
      count_in  = count_ff + RSP_CNT_WIDTH'(push.first) + RSP_CNT_WIDTH'(push.second)
                  - RSP_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         slot_ff[wr_ptr_ff] <= first_item;
      end
      if (push.second) begin
         slot_ff[wr_ptr_ff + 1'b1] <= second_item;
      end
   end

   assign out_item               = slot_ff[rd_ptr_ff];
   assign level                  = count_ff;
   assign rsp_chan.valid         = (count_ff != '0);
   assign rsp_chan.result_kind   = out_item.result_kind;
   assign rsp_chan.card_command  = out_item.card_command;
   assign rsp_chan.card_argument = out_item.card_argument;
   assign rsp_chan.data_length   = out_item.data_length;
   assign rsp_chan.data_control  = out_item.data_control;
   assign rsp_chan.dma_address   = out_item.dma_address;
   assign rsp_chan.done_tag      = out_item.done_tag;
   assign rsp_chan.failed        = out_item.failed;
   assign rsp_chan.error_status  = out_item.error_status;
   assign rsp_chan.last          = out_item.last;

endmodule

`default_nettype wire

// File: rtl/block_request_queue_with_retry.sv
`default_nettype none

// An item is registered at acceptance; any results it has enter the result queue once it
// proceeds, which it does only while the result queue has room for two results.
// Throughput: one item per cycle while the result queue has room for two results.
// Reset (synchronous): queue empty, retry count zero, byte addressing, retry limit 3.
// Request storage is not cleared; only entries written since are read.
module block_request_queue_with_retry
   import brq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   brq_req_if.sink                          req_chan,
   brq_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]   csr_write_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                     in_vld_ff;
   req_item_type             in_ff;
   logic                     hc_ff;
   logic [2:0]               limit_ff;
   logic [2:0]               retry_ff, retry_in;
   logic                     proceed;
   logic                     data_err;
   q_ctrl_type               q_ctrl;
   req_entry_type            head_entry;
   req_entry_type            next_entry;
   logic [CW-1:0]            q_count;
   rsp_push_type             rsp_push;
   rsp_item_type             first_item;
   rsp_item_type             second_item;
   logic [RSP_CNT_WIDTH-1:0] rsp_level;

   assign proceed = in_vld_ff && (rsp_level <= RSP_CNT_WIDTH'(RSP_DEPTH - 2));
   assign req_chan.ready = !in_vld_ff || proceed;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ff.command              <= req_chan.command;
         in_ff.entry.block_number   <= req_chan.block_number;
         in_ff.entry.is_read        <= req_chan.is_read;
         in_ff.entry.byte_count     <= req_chan.byte_count;
         in_ff.entry.buffer_address <= req_chan.buffer_address;
         in_ff.entry.request_tag    <= req_chan.request_tag;
         in_ff.transfer_status      <= req_chan.transfer_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff    <= 1'b0;
         limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HIGH_CAPACITY: hc_ff    <= csr_write_data[0];
            CSR_RETRY_LIMIT:   limit_ff <= csr_write_data;
         endcase
      end
   end

   assign data_err = |(in_ff.transfer_status & DATA_ERR_MASK);

   // a transfer is running exactly when the queue holds a request
   always_comb begin
      q_ctrl      = '0;
      rsp_push    = '0;
      first_item  = '0;
      second_item = '0;
      retry_in    = retry_ff;
      if (proceed) begin
         unique case (in_ff.command)
            CMD_SUBMIT: begin
               if (q_count == CW'(QUEUE_DEPTH)) begin
                  first_item.result_kind = KIND_REJECT;
                  first_item.done_tag    = in_ff.entry.request_tag;
                  first_item.last        = 1'b1;
                  rsp_push.first         = 1'b1;
               end else begin
                  q_ctrl.push = 1'b1;
                  if (q_count == '0) begin
                     retry_in       = '0;
                     first_item     = make_start(in_ff.entry, hc_ff);
                     rsp_push.first = 1'b1;
                  end
               end
            end
            CMD_EVENT: begin
               if (q_count != '0) begin
                  rsp_push.first = 1'b1;
                  if (data_err && (retry_ff < limit_ff)) begin
                     retry_in   = retry_ff + 1'b1;
                     first_item = make_start(head_entry, hc_ff);
                  end else begin
                     retry_in                = '0;
                     q_ctrl.pop              = 1'b1;
                     first_item.result_kind  = KIND_DONE;
                     first_item.done_tag     = head_entry.request_tag;
                     first_item.failed       = data_err;
                     first_item.error_status = data_err ? in_ff.transfer_status : '0;
                     first_item.last         = (q_count == CW'(1));
                     if (q_count != CW'(1)) begin
                        second_item     = make_start(next_entry, hc_ff);
                        rsp_push.second = 1'b1;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff <= '0;
      end else begin
         retry_ff <= retry_in;
      end
   end

   brq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (q_ctrl),
      .push_entry (in_ff.entry),
      .head_entry (head_entry),
      .next_entry (next_entry),
      .count      (q_count)
   );

   brq_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (rsp_push),
      .first_item  (first_item),
      .second_item (second_item),
      .level       (rsp_level),
      .rsp_chan    (rsp_chan)
   );

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CW'(QUEUE_DEPTH))
      else $error("request queue count beyond depth");

   a_retry_needs_head: assert property (@(posedge clock) disable iff (reset)
      retry_ff != '0 |-> q_count != '0)
      else $error("retry count held with empty queue");

   a_submit_enqueues: assert property (@(posedge clock) disable iff (reset)
      proceed && (in_ff.command == CMD_SUBMIT) && (q_count != CW'(QUEUE_DEPTH))
      |=> q_count == CW'($past(q_count) + 1'b1))
      else $error("accepted submit did not enqueue");

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_level <= RSP_CNT_WIDTH'(RSP_DEPTH))
      else $error("result queue overflow");
`endif

endmodule

`default_nettype wire
